// ===== hdl/hbs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Histogram bin search package
// Shared widths, operation codes and the table memory request type.
// ----------------------------------------------------------------------------
package hbs_pkg;

    localparam int DEFAULT_MAX_BINS = 256;
    localparam int DATA_W           = 32;
    localparam int IDX_W            = 8;
    localparam int CFG_W            = 9;
    localparam int STEPS_W          = 4;
    localparam int ENTRY_W          = 3 * DATA_W;
    localparam int ADDR_MAX_W       = 16;
    localparam int COUNT_W          = ADDR_MAX_W + 1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                  we;
        logic [ADDR_MAX_W-1:0] waddr;
        logic [ENTRY_W-1:0]    wdata;
        logic [ADDR_MAX_W-1:0] raddr;
    } ram_req_t;

endpackage
`default_nettype wire

// ===== hdl/hbs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module hbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/hbs_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Histogram bin search sequencer
// Stores bins and runs the span check and upper-middle binary search
// through one table read per cycle.
// ----------------------------------------------------------------------------
module hbs_core
    import hbs_pkg::*;
#(
    parameter int MAX_BINS = DEFAULT_MAX_BINS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic                      operation,
    input  wire logic [IDX_W-1:0]          bin_index,
    input  wire logic signed [DATA_W-1:0]  bin_low_edge,
    input  wire logic signed [DATA_W-1:0]  bin_high_edge,
    input  wire logic [DATA_W-1:0]         bin_height,
    input  wire logic signed [DATA_W-1:0]  query_position,
    input  wire logic [CFG_W-1:0]          bins_in_use,
    input  wire logic [ENTRY_W-1:0]        rd_data,
    output ram_req_t                       ram_req,
    output logic                           busy,
    output logic                           done,
    output logic                           found,
    output logic signed [DATA_W-1:0]       range_low,
    output logic signed [DATA_W-1:0]       range_high,
    output logic [DATA_W-1:0]              height,
    output logic [STEPS_W-1:0]             search_steps
);

    localparam int IW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK_LOW,
        S_CHK_HIGH,
        S_STEP,
        S_FINAL
    } state_t;

    state_t                     state_reg, state_next;
    logic [IW-1:0]              lo_reg, lo_next;
    logic [IW-1:0]              hi_reg, hi_next;
    logic signed [DATA_W-1:0]   pos_reg, pos_next;
    logic [STEPS_W-1:0]         steps_reg, steps_next;
    logic                       done_reg, done_next;
    logic                       found_reg, found_next;
    logic signed [DATA_W-1:0]   range_low_reg, range_low_next;
    logic signed [DATA_W-1:0]   range_high_reg, range_high_next;
    logic [DATA_W-1:0]          height_reg, height_next;
    logic [STEPS_W-1:0]         steps_out_reg, steps_out_next;

    logic [COUNT_W-1:0]         n_ext;
    logic [COUNT_W-1:0]         n_clamp;
    logic [COUNT_W-1:0]         idx_ext;
    logic [IW-1:0]              hi_init;
    logic [IW:0]                mid_sum;
    logic [IW-1:0]              mid_cur;
    logic [IW:0]                mid_sum_new;
    logic [IW-1:0]              mid_new;
    logic signed [DATA_W-1:0]   rd_low;
    logic signed [DATA_W-1:0]   rd_high;
    logic                       miss;

    assign n_ext   = COUNT_W'(bins_in_use);
    assign n_clamp = (n_ext > COUNT_W'(MAX_BINS)) ? COUNT_W'(MAX_BINS) : n_ext;
    assign idx_ext = COUNT_W'(bin_index);
    assign hi_init = IW'(n_clamp - COUNT_W'(1));

    assign rd_low  = $signed(rd_data[ENTRY_W-1 -: DATA_W]);
    assign rd_high = $signed(rd_data[ENTRY_W-DATA_W-1 -: DATA_W]);

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} + (IW+1)'(1);
    assign mid_cur = mid_sum[IW:1];

    always_comb
    begin
        state_next      = state_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        pos_next        = pos_reg;
        steps_next      = steps_reg;
        done_next       = 1'b0;
        found_next      = found_reg;
        range_low_next  = range_low_reg;
        range_high_next = range_high_reg;
        height_next     = height_reg;
        steps_out_next  = steps_out_reg;
        miss            = 1'b0;
        mid_sum_new     = '0;
        mid_new         = '0;

        ram_req       = '0;
        ram_req.waddr = ADDR_MAX_W'(bin_index);
        ram_req.wdata = {bin_low_edge, bin_high_edge, bin_height};
        ram_req.raddr = ADDR_MAX_W'(lo_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                ram_req.raddr = '0;
                if (start)
                begin
                    if (operation == OP_WRITE)
                    begin
                        ram_req.we = (idx_ext < COUNT_W'(MAX_BINS));
                    end
                    else
                    begin
                        pos_next   = query_position;
                        lo_next    = '0;
                        hi_next    = hi_init;
                        steps_next = '0;
                        if (n_clamp == '0)
                        begin
                            miss = 1'b1;
                        end
                        else
                        begin
                            state_next = S_CHK_LOW;
                        end
                    end
                end
            end
            S_CHK_LOW:
            begin
                if (pos_reg < rd_low)
                begin
                    miss = 1'b1;
                end
                else
                begin
                    ram_req.raddr = ADDR_MAX_W'(hi_reg);
                    state_next    = S_CHK_HIGH;
                end
            end
            S_CHK_HIGH:
            begin
                if (pos_reg > rd_high)
                begin
                    miss = 1'b1;
                end
                else if (lo_reg == hi_reg)
                begin
                    ram_req.raddr = ADDR_MAX_W'(lo_reg);
                    state_next    = S_FINAL;
                end
                else
                begin
                    ram_req.raddr = ADDR_MAX_W'(mid_cur);
                    state_next    = S_STEP;
                end
            end
            S_STEP:
            begin
                if (pos_reg < rd_low)
                begin
                    hi_next = mid_cur - IW'(1);
                end
                else
                begin
                    lo_next = mid_cur;
                end
                steps_next  = steps_reg + STEPS_W'(1);
                mid_sum_new = {1'b0, lo_next} + {1'b0, hi_next} + (IW+1)'(1);
                mid_new     = mid_sum_new[IW:1];
                if (lo_next == hi_next)
                begin
                    ram_req.raddr = ADDR_MAX_W'(lo_next);
                    state_next    = S_FINAL;
                end
                else
                begin
                    ram_req.raddr = ADDR_MAX_W'(mid_new);
                end
            end
            S_FINAL:
            begin
                done_next       = 1'b1;
                found_next      = 1'b1;
                range_low_next  = rd_low;
                range_high_next = rd_high;
                height_next     = rd_data[DATA_W-1:0];
                steps_out_next  = steps_reg;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (miss)
        begin
            done_next       = 1'b1;
            found_next      = 1'b0;
            range_low_next  = '0;
            range_high_next = '0;
            height_next     = '0;
            steps_out_next  = '0;
            state_next      = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        pos_reg        <= pos_next;
        steps_reg      <= steps_next;
        found_reg      <= found_next;
        range_low_reg  <= range_low_next;
        range_high_reg <= range_high_next;
        height_reg     <= height_next;
        steps_out_reg  <= steps_out_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign found        = found_reg;
    assign range_low    = range_low_reg;
    assign range_high   = range_high_reg;
    assign height       = height_reg;
    assign search_steps = steps_out_reg;

endmodule
`default_nettype wire

// ===== hdl/histogram_bin_search_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Histogram bin search
// Bin table in one RAM, searched by position with an upper-middle binary
// search. A write item gives no result.
// A query holds busy while it makes one table read per cycle: first-edge
// check, last-edge check, each halving step, final bin fetch. done pulses
// in the cycle after the final fetch, and the next item can be accepted in
// that done cycle. An out-of-span query holds busy only until the failing
// edge check; with no bins in use done follows the query directly.
// The receiver cannot stall.
// Reset clears control and bins_in_use; the table itself is not cleared.
// ----------------------------------------------------------------------------
module histogram_bin_search_top
    import hbs_pkg::*;
#(
    parameter int MAX_BINS = DEFAULT_MAX_BINS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      operation,
    input  wire logic [IDX_W-1:0]          bin_index,
    input  wire logic signed [DATA_W-1:0]  bin_low_edge,
    input  wire logic signed [DATA_W-1:0]  bin_high_edge,
    input  wire logic [DATA_W-1:0]         bin_height,
    input  wire logic signed [DATA_W-1:0]  query_position,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_W-1:0]          cfg_data,
    output logic                           done,
    output logic                           found,
    output logic signed [DATA_W-1:0]       range_low,
    output logic signed [DATA_W-1:0]       range_high,
    output logic [DATA_W-1:0]              height,
    output logic [STEPS_W-1:0]             search_steps
);

    localparam int IW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

    logic [CFG_W-1:0]   bins_in_use_reg;
    ram_req_t           ram_req;
    logic [ENTRY_W-1:0] rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins_in_use_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            bins_in_use_reg <= cfg_data;
        end
    end

    hbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BINS)
    ) u_table (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr[IW-1:0]),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr[IW-1:0]),
        .rdata (rd_data)
    );

    hbs_core #(
        .MAX_BINS (MAX_BINS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .operation      (operation),
        .bin_index      (bin_index),
        .bin_low_edge   (bin_low_edge),
        .bin_high_edge  (bin_high_edge),
        .bin_height     (bin_height),
        .query_position (query_position),
        .bins_in_use    (bins_in_use_reg),
        .rd_data        (rd_data),
        .ram_req        (ram_req),
        .busy           (busy),
        .done           (done),
        .found          (found),
        .range_low      (range_low),
        .range_high     (range_high),
        .height         (height),
        .search_steps   (search_steps)
    );

endmodule
`default_nettype wire

// ===== bench/histogram_bin_search_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Histogram bin search testbench
// Loads bin tables, mostly sorted with random spans, widths, gaps and
// touching edges, and sends position queries at, inside and around the
// bins. A built-in predictor of the upper-middle search produces the
// expected result for every query. Each result strobe is checked field by
// field. bins_in_use is changed only while the block is idle, across
// phases that use different sender gap rates.
// ----------------------------------------------------------------------------
module histogram_bin_search_top_tb;
    import hbs_pkg::*;

    localparam int TABLE_DEPTH = DEFAULT_MAX_BINS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 550;
    localparam longint WORD_MIN = -64'sh8000_0000;
    localparam longint WORD_MAX = 64'sh7FFF_FFFF;

    typedef struct {
        logic                     op;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] low_edge;
        logic signed [DATA_W-1:0] high_edge;
        logic [DATA_W-1:0]        count;
        logic signed [DATA_W-1:0] position;
    } bin_item_t;

    typedef struct {
        logic                     found;
        logic signed [DATA_W-1:0] range_low;
        logic signed [DATA_W-1:0] range_high;
        logic [DATA_W-1:0]        height;
        logic [STEPS_W-1:0]       steps;
    } bin_hit_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic operation = OP_WRITE;
    logic [IDX_W-1:0] bin_index = '0;
    logic signed [DATA_W-1:0] bin_low_edge = '0;
    logic signed [DATA_W-1:0] bin_high_edge = '0;
    logic [DATA_W-1:0] bin_height = '0;
    logic signed [DATA_W-1:0] query_position = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;
    logic done;
    logic found;
    logic signed [DATA_W-1:0] range_low;
    logic signed [DATA_W-1:0] range_high;
    logic [DATA_W-1:0] height;
    logic [STEPS_W-1:0] search_steps;

    bin_item_t item_queue[$];
    bin_hit_t  pending_hits[$];
    logic      item_taken = 1'b0;
    int        gap_pct = 0;
    int        error_count = 0;
    int        cycle_count = 0;

    // predictor copy of the table and register
    logic signed [DATA_W-1:0] edge_lo[TABLE_DEPTH];
    logic signed [DATA_W-1:0] edge_hi[TABLE_DEPTH];
    logic [DATA_W-1:0]        bin_count[TABLE_DEPTH];
    logic [CFG_W-1:0]         active_bins = '0;

    // table contents as planned by the stimulus
    logic signed [DATA_W-1:0] plan_lo[TABLE_DEPTH];
    logic signed [DATA_W-1:0] plan_hi[TABLE_DEPTH];
    int                       plan_bins = 0;

    histogram_bin_search_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .bin_index      (bin_index),
        .bin_low_edge   (bin_low_edge),
        .bin_high_edge  (bin_high_edge),
        .bin_height     (bin_height),
        .query_position (query_position),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .done           (done),
        .found          (found),
        .range_low      (range_low),
        .range_high     (range_high),
        .height         (height),
        .search_steps   (search_steps)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bin_hit_t search_bins(logic signed [DATA_W-1:0] pos);
        bin_hit_t hit;
        int n;
        int lo;
        int hi;
        int mid;
        int steps;
        hit = '{default: '0};
        n = (active_bins > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_bins);
        if (n == 0)
            return hit;
        lo = 0;
        hi = n - 1;
        if (pos < edge_lo[lo] || pos > edge_hi[hi])
            return hit;
        steps = 0;
        while (lo != hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (pos < edge_lo[mid])
                hi = mid - 1;
            else
                lo = mid;
            steps++;
        end
        hit.found      = 1'b1;
        hit.range_low  = edge_lo[lo];
        hit.range_high = edge_hi[lo];
        hit.height     = bin_count[lo];
        hit.steps      = steps[STEPS_W-1:0];
        return hit;
    endfunction

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_and_predict
        bin_hit_t want;
        if (!rst_n)
        begin
            item_taken <= 1'b0;
            active_bins = '0;
        end
        else
        begin
            if (done)
            begin
                if (pending_hits.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual found=%b low=%h",
                             $time, found, range_low);
                    error_count++;
                end
                else
                begin
                    want = pending_hits.pop_front();
                    check_field("found", 32'(want.found), 32'(found));
                    check_field("range_low", want.range_low, range_low);
                    check_field("range_high", want.range_high, range_high);
                    check_field("height", want.height, height);
                    check_field("search_steps", 32'(want.steps), 32'(search_steps));
                end
            end
            if (cfg_valid && cfg_ready)
                active_bins = cfg_data;
            item_taken <= start && !busy;
            if (start && !busy)
            begin
                if (operation == OP_WRITE)
                begin
                    edge_lo[bin_index]   = bin_low_edge;
                    edge_hi[bin_index]   = bin_high_edge;
                    bin_count[bin_index] = bin_height;
                end
                else
                    pending_hits.push_back(search_bins(query_position));
            end
        end
    end

    always @(negedge clk)
    begin : drive_items
        bin_item_t it;
        if (!rst_n)
            start <= 1'b0;
        else if (!start || item_taken)
        begin
            if (item_queue.size() != 0 && $urandom_range(0, 99) >= gap_pct)
            begin
                it = item_queue.pop_front();
                operation      <= it.op;
                bin_index      <= it.idx;
                bin_low_edge   <= it.low_edge;
                bin_high_edge  <= it.high_edge;
                bin_height     <= it.count;
                query_position <= it.position;
                start          <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("histogram_bin_search_top verification failed");
            $finish;
        end
    end

    task automatic push_write(input int idx, input logic signed [DATA_W-1:0] lo,
                              input logic signed [DATA_W-1:0] hi,
                              input logic [DATA_W-1:0] count);
        bin_item_t it;
        it.op        = OP_WRITE;
        it.idx       = idx[IDX_W-1:0];
        it.low_edge  = lo;
        it.high_edge = hi;
        it.count     = count;
        it.position  = $urandom;
        plan_lo[idx] = lo;
        plan_hi[idx] = hi;
        item_queue.push_back(it);
    endtask

    task automatic push_query(input logic signed [DATA_W-1:0] pos);
        bin_item_t it;
        it.op        = OP_QUERY;
        it.idx       = $urandom;
        it.low_edge  = $urandom;
        it.high_edge = $urandom;
        it.count     = $urandom;
        it.position  = pos;
        item_queue.push_back(it);
    endtask

    // hold the sender until the block has gone quiet
    task automatic wait_idle();
        while (item_queue.size() != 0 || start)
            @(posedge clk);
        repeat (16) @(posedge clk);
        while (pending_hits.size() != 0 || busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_bins_in_use(input int value);
        wait_idle();
        cfg_data  <= value[CFG_W-1:0];
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        plan_bins = (value > TABLE_DEPTH) ? TABLE_DEPTH : value;
    endtask

    function automatic logic [DATA_W-1:0] pick_height();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // sorted bins over a random span: contiguous, gapped or touching
    task automatic fill_sorted(input int k);
        longint step;
        longint base;
        longint lo_v;
        longint hi_v;
        longint slack;
        int sel;
        if ($urandom_range(0, 1) == 1)
            step = 64'sh1_0000_0000 / k;
        else
            step = $urandom_range(2, 32'h0004_0000);
        slack = 64'sh1_0000_0000 - step * k;
        base = WORD_MIN + longint'($urandom_range(0, 32'(slack)));
        for (int i = 0; i < k; i++)
        begin
            lo_v = base + i * step;
            sel = $urandom_range(0, 99);
            if (sel < 25)
                hi_v = lo_v + longint'($urandom_range(0, 32'(step - 1)));
            else if (sel < 40 && i < k - 1)
                hi_v = lo_v + step;
            else
                hi_v = lo_v + step - 1;
            push_write(i, lo_v[DATA_W-1:0], hi_v[DATA_W-1:0], pick_height());
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_position(input int n);
        longint lo_v;
        longint hi_v;
        longint p;
        int j;
        int sel;
        if (n == 0)
            return $urandom;
        j = $urandom_range(0, n - 1);
        lo_v = plan_lo[j];
        hi_v = plan_hi[j];
        sel = $urandom_range(0, 99);
        if (sel < 25)
            p = lo_v;
        else if (sel < 40)
            p = hi_v;
        else if (sel < 70)
            p = (hi_v >= lo_v) ? lo_v + (longint'($urandom) % (hi_v - lo_v + 1)) : lo_v;
        else if (sel < 78)
            p = (plan_lo[0] == WORD_MIN) ? WORD_MIN : longint'(plan_lo[0]) - 1;
        else if (sel < 86)
            p = (plan_hi[n-1] == WORD_MAX) ? WORD_MAX : longint'(plan_hi[n-1]) + 1;
        else if (sel < 90)
            p = WORD_MIN;
        else if (sel < 94)
            p = WORD_MAX;
        else
            p = $urandom;
        return p[DATA_W-1:0];
    endfunction

    initial
    begin : stimulus
        int random_items;
        int phase;
        int n;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table, then a four-bin table with exact edges and both outer sides, then one bin
        write_bins_in_use(0);
        push_query(32'sh0000_0000);
        push_query(32'sh7FFF_FFFF);
        push_write(0, -32'sh0064_0000, -32'sh0032_0000, 32'h0000_0000);
        push_write(1, -32'sh0032_0000, 32'sh0000_0000, 32'hFFFF_FFFF);
        push_write(2, 32'sh0000_0000, 32'sh0032_0000, 32'h0000_0005);
        push_write(3, 32'sh0032_0000, 32'sh0064_0000, 32'h1234_5678);
        push_write(255, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
        write_bins_in_use(4);
        push_query(32'sh8000_0000);
        push_query(-32'sh0064_0001);
        push_query(-32'sh0064_0000);
        push_query(-32'sh0000_0001);
        push_query(32'sh0000_0000);
        push_query(32'sh0000_0100);
        push_query(32'sh0064_0000);
        push_query(32'sh0064_0001);
        push_query(32'sh7FFF_FFFF);
        write_bins_in_use(1);
        push_query(-32'sh0064_0000);
        push_query(-32'sh0032_0000);
        push_query(32'sh0000_0000);

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            case (phase % 3)
                0:       gap_pct = 0;
                1:       gap_pct = 56;
                default: gap_pct = 25;
            endcase
            if (phase == 0)
                n = TABLE_DEPTH;
            else if (phase == 1)
                n = 511;
            else if ($urandom_range(0, 3) == 0)
                n = $urandom_range(0, 511);
            else
                n = $urandom_range(0, 24);
            write_bins_in_use(n);
            if (phase == 0 || (plan_bins > 0 && plan_bins <= 40 && $urandom_range(0, 1) == 1))
            begin
                fill_sorted(plan_bins);
                random_items += plan_bins;
            end
            for (int k = 0; k < 35; k++)
            begin
                if ($urandom_range(0, 99) < 10)
                    push_write($urandom_range(0, TABLE_DEPTH - 1), $urandom, $urandom,
                               pick_height());
                else
                    push_query(pick_position(plan_bins));
                random_items++;
            end
            phase++;
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (error_count == 0 && pending_hits.size() == 0)
            $display("histogram_bin_search_top verification clean");
        else
            $display("histogram_bin_search_top verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/hbs_pkg.sv
hdl/hbs_ram.sv
hdl/hbs_core.sv
hdl/histogram_bin_search_top.sv
bench/histogram_bin_search_top_tb.sv
